[rtl/pgn_pkg.sv]
// Shared constants, types and helper functions of the 2-D gradient noise block.
package pgn_pkg;

    localparam int TABLE_SIZE = 256;
    localparam int FRAC_BITS  = 12;
    localparam int IDX_W      = $clog2(TABLE_SIZE);
    localparam int ONE_FIX    = 1 << FRAC_BITS;
    localparam int HALF_FIX   = 1 << (FRAC_BITS - 1);
    localparam int COORD_W    = 20;
    localparam int NOISE_W    = 16;
    localparam int SEED_W     = 32;
    localparam int RND_W      = 24;
    localparam int ADDR_W     = 3;
    localparam int U_W        = FRAC_BITS + 1;
    localparam int GRAD_W     = FRAC_BITS + 3;
    localparam int DIFF_W     = FRAC_BITS + 6;
    localparam int PROD_W     = DIFF_W + U_W + 1;

    localparam logic CMD_REBUILD = 1'b0;
    localparam logic CMD_NOISE   = 1'b1;
    localparam logic REG_SEED    = 1'b0;

    typedef enum logic [4:0] {
        ST_IDLE, ST_RB_INIT, ST_RB_RNG, ST_RB_MUL, ST_RB_RDI, ST_RB_RDJ, ST_RB_WRI,
        ST_RB_WRJ, ST_RB_FIN, ST_N_RA, ST_N_RB, ST_N_R00, ST_N_R01, ST_N_R10,
        ST_N_R11, ST_N_H11, ST_N_M0, ST_N_A0M1, ST_N_A1, ST_N_M2, ST_N_FIN
    } state_t;

    typedef enum logic [2:0] {
        RD_I, RD_J, RD_XI, RD_XN, RD_A_YI, RD_A_YN, RD_B_YI, RD_B_YN
    } rd_src_t;

    typedef enum logic [1:0] { WR_NONE, WR_I, WR_J } wr_sel_t;

    typedef enum logic [2:0] {
        CAP_NONE, CAP_PI, CAP_A, CAP_B, CAP_H00, CAP_H01, CAP_H10, CAP_H11
    } cap_sel_t;

    typedef enum logic [1:0] { MUL_U0, MUL_U1, MUL_V } mul_sel_t;

    typedef enum logic [1:0] { ADD_NONE, ADD_L0, ADD_L1 } add_sel_t;

    typedef struct packed {
        logic     load_in;
        logic     rb_init;
        logic     rng_step;
        logic     calc_j;
        logic     i_dec;
        logic     rd_en;
        rd_src_t  rd_src;
        wr_sel_t  wr_sel;
        cap_sel_t cap_sel;
        logic     mul_en;
        mul_sel_t mul_sel;
        add_sel_t add_sel;
        logic     res_noise;
        logic     res_rebuild;
    } ctrl_cmd_t;

    typedef struct packed {
        logic i_last;
    } dp_status_t;

    function automatic logic [SEED_W-1:0] xs_next(input logic [SEED_W-1:0] s);
        logic [SEED_W-1:0] t;
        t = s ^ (s << 13);
        t = t ^ (t >> 17);
        t = t ^ (t << 5);
        return t;
    endfunction

    function automatic logic signed [GRAD_W-1:0] grad(
        input logic [1:0]               h,
        input logic signed [GRAD_W-1:0] dx,
        input logic signed [GRAD_W-1:0] dy
    );
        logic signed [GRAD_W-1:0] g;
        case (h)
            2'd0:    g = dx + dy;
            2'd1:    g = dy - dx;
            2'd2:    g = dx - dy;
            default: g = -dx - dy;
        endcase
        return g;
    endfunction

endpackage

[rtl/pgn_fade.sv]
// Four-stage pipeline for the quintic fade of one fraction.
module pgn_fade (
    input  logic                        clk,
    input  logic [pgn_pkg::FRAC_BITS-1:0] f,
    output logic [pgn_pkg::U_W-1:0]       u
);
    import pgn_pkg::*;

    localparam int F    = FRAC_BITS;
    localparam int QW   = 2 * F + 5;
    localparam int QF_W = F + 4;
    localparam int PW   = 2 * F + 6;

    logic [2*F-1:0]  ff_reg;
    logic [F-1:0]    f1_reg;
    logic [F-1:0]    f2d_reg;
    logic [QF_W-1:0] qf_reg;
    logic [QF_W-1:0] qf3_reg;
    logic [F:0]      f2_reg;
    logic [F:0]      f3_reg;
    logic [U_W-1:0]  u_reg;

    logic [QW-1:0]   q;
    logic [QW-1:0]   q_r;
    logic [2*F:0]    ff_r;
    logic [2*F+1:0]  f3_p;
    logic [PW-1:0]   u_p;
    logic [PW-F-1:0] u_full;

    always_comb
    begin
        q      = QW'(ff_reg) * QW'(6) + (QW'(10) << (2 * F))
               - ((QW'(f1_reg) * QW'(15)) << F);
        q_r    = (q + QW'(HALF_FIX)) >> F;
        ff_r   = ((2 * F + 1)'(ff_reg) + (2 * F + 1)'(HALF_FIX)) >> F;
        f3_p   = ((2 * F + 2)'(f2_reg) * (2 * F + 2)'(f2d_reg) + (2 * F + 2)'(HALF_FIX)) >> F;
        u_p    = PW'(f3_reg) * PW'(qf3_reg) + PW'(HALF_FIX);
        u_full = u_p[PW-1:F];
    end

    always_ff @(posedge clk)
    begin
        ff_reg  <= f * f;
        f1_reg  <= f;
        qf_reg  <= q_r[QF_W-1:0];
        f2_reg  <= ff_r[F:0];
        f2d_reg <= f1_reg;
        f3_reg  <= f3_p[F:0];
        qf3_reg <= qf_reg;
        u_reg   <= (u_full > (PW - F)'(ONE_FIX)) ? U_W'(ONE_FIX) : u_full[U_W-1:0];
    end

    assign u = u_reg;

endmodule

[rtl/pgn_datapath.sv]
// Datapath: permutation memory, shuffle generator, corner hashing, fade and blend.
module pgn_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  pgn_pkg::ctrl_cmd_t          ctl,
    output pgn_pkg::dp_status_t         status,
    input  logic [pgn_pkg::SEED_W-1:0]  seed,
    input  logic [pgn_pkg::COORD_W-1:0] x_coord,
    input  logic [pgn_pkg::COORD_W-1:0] y_coord,
    output logic [pgn_pkg::NOISE_W-1:0] noise_value,
    output logic                        rebuild_done
);
    import pgn_pkg::*;

    logic [IDX_W-1:0]  mem [TABLE_SIZE];
    logic [TABLE_SIZE-1:0] vld_reg;
    logic [IDX_W-1:0]  rd_data_reg;
    logic [IDX_W-1:0]  rd_addr_reg;
    logic              rd_vld_reg;

    logic [SEED_W-1:0] rng_reg;
    logic [IDX_W-1:0]  i_reg;
    logic [IDX_W-1:0]  j_reg;
    logic [IDX_W-1:0]  pi_reg;
    logic [IDX_W-1:0]  xi_reg, yi_reg, a_reg, b_reg;
    logic [FRAC_BITS-1:0] xf_reg, yf_reg;
    logic [1:0]        h00_reg, h01_reg, h10_reg, h11_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [DIFF_W-1:0] l0_reg, l1_reg;
    logic [NOISE_W-1:0] noise_reg;
    logic              done_reg;

    logic [IDX_W-1:0]  perm_out;
    logic [IDX_W-1:0]  rd_addr;
    logic [IDX_W-1:0]  wr_addr;
    logic [IDX_W-1:0]  wr_data;
    logic [IDX_W-1:0]  xn, yn;
    logic [U_W-1:0]    u, v;
    logic [RND_W+IDX_W:0] j_prod;
    logic signed [GRAD_W-1:0] dx0, dx1, dy0, dy1;
    logic signed [GRAD_W-1:0] g00, g10, g01, g11;
    logic signed [DIFF_W-1:0] ma, mb, diff, rnd, lsum;
    logic [U_W-1:0]    mf;
    logic signed [PROD_W-1:0] mprod, prnd;
    logic signed [DIFF_W+1:0] o;

    pgn_fade u_fade_x (.clk(clk), .f(xf_reg), .u(u));
    pgn_fade u_fade_y (.clk(clk), .f(yf_reg), .u(v));

    assign perm_out = rd_vld_reg ? rd_data_reg : rd_addr_reg;
    assign xn = xi_reg + 1'b1;
    assign yn = yi_reg + 1'b1;
    assign status.i_last = (i_reg == IDX_W'(1));

    always_comb
    begin
        case (ctl.rd_src)
            RD_I:    rd_addr = i_reg;
            RD_J:    rd_addr = j_reg;
            RD_XI:   rd_addr = xi_reg;
            RD_XN:   rd_addr = xn;
            RD_A_YI: rd_addr = a_reg + yi_reg;
            RD_A_YN: rd_addr = a_reg + yn;
            RD_B_YI: rd_addr = b_reg + yi_reg;
            RD_B_YN: rd_addr = b_reg + yn;
            default: rd_addr = i_reg;
        endcase
        wr_addr = (ctl.wr_sel == WR_J) ? j_reg : i_reg;
        wr_data = (ctl.wr_sel == WR_J) ? pi_reg : perm_out;
        j_prod  = (RND_W + IDX_W + 1)'(rng_reg[RND_W-1:0])
                * (RND_W + IDX_W + 1)'({1'b0, i_reg} + 1'b1);
    end

    // Gradient offsets and corner gradients
    always_comb
    begin
        dx0 = $signed({{(GRAD_W-FRAC_BITS){1'b0}}, xf_reg});
        dy0 = $signed({{(GRAD_W-FRAC_BITS){1'b0}}, yf_reg});
        dx1 = dx0 - GRAD_W'(ONE_FIX);
        dy1 = dy0 - GRAD_W'(ONE_FIX);
        g00 = grad(h00_reg, dx0, dy0);
        g10 = grad(h10_reg, dx1, dy0);
        g01 = grad(h01_reg, dx0, dy1);
        g11 = grad(h11_reg, dx1, dy1);
    end

    // One shared multiplier for the three blends
    always_comb
    begin
        case (ctl.mul_sel)
            MUL_U0:
            begin
                ma = DIFF_W'(g00);
                mb = DIFF_W'(g10);
                mf = u;
            end
            MUL_U1:
            begin
                ma = DIFF_W'(g01);
                mb = DIFF_W'(g11);
                mf = u;
            end
            default:
            begin
                ma = l0_reg;
                mb = l1_reg;
                mf = v;
            end
        endcase
        diff  = mb - ma;
        mprod = PROD_W'($signed({1'b0, mf}) * diff);
        prnd  = (prod_reg + PROD_W'(HALF_FIX)) >>> FRAC_BITS;
        rnd   = prnd[DIFF_W-1:0];
        lsum  = l0_reg + rnd;
        o     = {lsum, 2'b00};
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_sel != WR_NONE)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
            rng_reg    <= SEED_W'(1);
        end
        else
        begin
            if (ctl.rb_init)
            begin
                vld_reg <= '0;
            end
            else if (ctl.wr_sel != WR_NONE)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (ctl.rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
            if (ctl.rb_init)
            begin
                rng_reg <= (seed == '0) ? SEED_W'(1) : seed;
            end
            else if (ctl.rng_step)
            begin
                rng_reg <= xs_next(rng_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_in)
        begin
            xi_reg <= x_coord[FRAC_BITS +: IDX_W];
            yi_reg <= y_coord[FRAC_BITS +: IDX_W];
            xf_reg <= x_coord[FRAC_BITS-1:0];
            yf_reg <= y_coord[FRAC_BITS-1:0];
        end
        if (ctl.rb_init)
        begin
            i_reg <= IDX_W'(TABLE_SIZE - 1);
        end
        else if (ctl.i_dec)
        begin
            i_reg <= i_reg - 1'b1;
        end
        if (ctl.calc_j)
        begin
            j_reg <= j_prod[RND_W +: IDX_W];
        end
        case (ctl.cap_sel)
            CAP_PI:  pi_reg  <= perm_out;
            CAP_A:   a_reg   <= perm_out;
            CAP_B:   b_reg   <= perm_out;
            CAP_H00: h00_reg <= perm_out[1:0];
            CAP_H01: h01_reg <= perm_out[1:0];
            CAP_H10: h10_reg <= perm_out[1:0];
            CAP_H11: h11_reg <= perm_out[1:0];
            default: ;
        endcase
        if (ctl.mul_en)
        begin
            prod_reg <= mprod;
        end
        case (ctl.add_sel)
            ADD_L0:  l0_reg <= DIFF_W'(g00) + rnd;
            ADD_L1:  l1_reg <= DIFF_W'(g01) + rnd;
            default: ;
        endcase
        if (ctl.res_noise)
        begin
            done_reg <= 1'b0;
            if (o > (DIFF_W + 2)'(32767))
            begin
                noise_reg <= 16'h7fff;
            end
            else if (o < -(DIFF_W + 2)'(32768))
            begin
                noise_reg <= 16'h8000;
            end
            else
            begin
                noise_reg <= o[NOISE_W-1:0];
            end
        end
        else if (ctl.res_rebuild)
        begin
            done_reg  <= 1'b1;
            noise_reg <= '0;
        end
    end

    assign noise_value  = noise_reg;
    assign rebuild_done = done_reg;

endmodule

[rtl/pgn_ctrl.sv]
// Controller state machine: sequences rebuild and noise items, owns output valid.
module pgn_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                cmd,
    output logic                out_valid,
    input  logic                out_ready,
    output pgn_pkg::ctrl_cmd_t  ctl,
    input  pgn_pkg::dp_status_t status
);
    import pgn_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.load_in = 1'b1;
                    state_next  = (cmd == CMD_NOISE) ? ST_N_RA : ST_RB_INIT;
                end
            end
            ST_RB_INIT:
            begin
                ctl.rb_init = 1'b1;
                state_next  = ST_RB_RNG;
            end
            ST_RB_RNG:
            begin
                ctl.rng_step = 1'b1;
                state_next   = ST_RB_MUL;
            end
            ST_RB_MUL:
            begin
                ctl.calc_j = 1'b1;
                state_next = ST_RB_RDI;
            end
            ST_RB_RDI:
            begin
                ctl.rd_en  = 1'b1;
                ctl.rd_src = RD_I;
                state_next = ST_RB_RDJ;
            end
            ST_RB_RDJ:
            begin
                ctl.rd_en   = 1'b1;
                ctl.rd_src  = RD_J;
                ctl.cap_sel = CAP_PI;
                state_next  = ST_RB_WRI;
            end
            ST_RB_WRI:
            begin
                ctl.wr_sel = WR_I;
                state_next = ST_RB_WRJ;
            end
            ST_RB_WRJ:
            begin
                ctl.wr_sel   = WR_J;
                ctl.rng_step = 1'b1;
                ctl.i_dec    = 1'b1;
                state_next   = status.i_last ? ST_RB_FIN : ST_RB_MUL;
            end
            ST_RB_FIN:
            begin
                if (out_free)
                begin
                    ctl.res_rebuild = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_N_RA:
            begin
                ctl.rd_en  = 1'b1;
                ctl.rd_src = RD_XI;
                state_next = ST_N_RB;
            end
            ST_N_RB:
            begin
                ctl.rd_en   = 1'b1;
                ctl.rd_src  = RD_XN;
                ctl.cap_sel = CAP_A;
                state_next  = ST_N_R00;
            end
            ST_N_R00:
            begin
                ctl.rd_en   = 1'b1;
                ctl.rd_src  = RD_A_YI;
                ctl.cap_sel = CAP_B;
                state_next  = ST_N_R01;
            end
            ST_N_R01:
            begin
                ctl.rd_en   = 1'b1;
                ctl.rd_src  = RD_A_YN;
                ctl.cap_sel = CAP_H00;
                state_next  = ST_N_R10;
            end
            ST_N_R10:
            begin
                ctl.rd_en   = 1'b1;
                ctl.rd_src  = RD_B_YI;
                ctl.cap_sel = CAP_H01;
                state_next  = ST_N_R11;
            end
            ST_N_R11:
            begin
                ctl.rd_en   = 1'b1;
                ctl.rd_src  = RD_B_YN;
                ctl.cap_sel = CAP_H10;
                state_next  = ST_N_H11;
            end
            ST_N_H11:
            begin
                ctl.cap_sel = CAP_H11;
                state_next  = ST_N_M0;
            end
            ST_N_M0:
            begin
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = MUL_U0;
                state_next  = ST_N_A0M1;
            end
            ST_N_A0M1:
            begin
                ctl.add_sel = ADD_L0;
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = MUL_U1;
                state_next  = ST_N_A1;
            end
            ST_N_A1:
            begin
                ctl.add_sel = ADD_L1;
                state_next  = ST_N_M2;
            end
            ST_N_M2:
            begin
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = MUL_V;
                state_next  = ST_N_FIN;
            end
            ST_N_FIN:
            begin
                if (out_free)
                begin
                    ctl.res_noise = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        out_valid_next = (ctl.res_noise || ctl.res_rebuild) ? 1'b1
                       : (out_ready ? 1'b0 : out_valid_reg);
    end

    assign out_valid = out_valid_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while an item is in flight");

    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_RB_FIN || $past(state_reg) == ST_N_FIN))
        else $error("result appeared outside a finishing state");

    a_shuffle_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RB_WRJ && status.i_last) |=> (state_reg == ST_RB_FIN))
        else $error("shuffle loop did not end at the last entry");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.res_noise || ctl.res_rebuild) |-> out_free)
        else $error("result written over one not yet taken");

endmodule

[rtl/perlin_gradient_noise_2d_top.sv]
// Top level of the 2-D gradient noise block: APB seed register, controller, datapath.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one item: cmd, x_coord, y_coord.
//   cmd = 0 rebuilds the 256-entry permutation from the seed register
//   (a seed of zero acts as one); cmd = 1 evaluates noise at the unsigned
//   Q8.12 point (x_coord, y_coord).
//   Output channel (out_valid/out_ready) returns one item per input item:
//   noise_value (signed Q1.14, saturated; zero for rebuilds) and
//   rebuild_done (high for rebuilds).
//   Sequence: a noise item runs from acceptance to its result through six
//   dependent reads of the permutation memory, which has one read port, and
//   three blends through one shared multiplier. A rebuild runs one shuffle
//   step per entry from the last down to entry 1 (index multiply, two reads,
//   two writes, generator advancing with the last write). One item is in work at a time.
//   The output register holds a finished item while the receiver stalls;
//   the next item is still accepted and runs until its result is due, then
//   waits for the register to free up.
//   Reset: permutation reads as the identity (per-entry valid bits, no
//   clearing pass), generator state is one, seed register is zero.
//   The seed register is at byte address 0; writing it does not rebuild.
module perlin_gradient_noise_2d_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        cmd,
    input  logic [pgn_pkg::COORD_W-1:0] x_coord,
    input  logic [pgn_pkg::COORD_W-1:0] y_coord,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [pgn_pkg::NOISE_W-1:0] noise_value,
    output logic                        rebuild_done,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pgn_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import pgn_pkg::*;

    logic [SEED_W-1:0] seed_reg;
    ctrl_cmd_t         ctl;
    dp_status_t        status;

    assign pready = 1'b1;

    // Seed register: write on the access phase, only index 0 exists
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
        end
        else if (psel && penable && pwrite && paddr[2] == REG_SEED)
        begin
            seed_reg <= pwdata;
        end
    end

    assign prdata = (paddr[2] == REG_SEED) ? seed_reg : 32'd0;

    pgn_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ctl       (ctl),
        .status    (status)
    );

    pgn_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .status       (status),
        .seed         (seed_reg),
        .x_coord      (x_coord),
        .y_coord      (y_coord),
        .noise_value  (noise_value),
        .rebuild_done (rebuild_done)
    );

endmodule
